// ===== hw/rtl/gzip_header_skipper_defines.svh =====
// Assertion macros shared by the gzip header skipper RTL.
`ifndef GZIP_HEADER_SKIPPER_DEFINES_SVH
`define GZIP_HEADER_SKIPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GZHS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GZHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/gzhs_pkg.sv =====
// Types and constants shared by the gzip header skipper modules.
package gzhs_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [1:0] kind;
      logic [7:0] header_flags;
   } rsp_type;

   localparam logic [1:0] KIND_HEADER     = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD    = 2'd1;
   localparam logic [1:0] KIND_BAD_MAGIC  = 2'd2;
   localparam logic [1:0] KIND_BAD_METHOD = 2'd3;

   localparam logic [7:0] MAGIC_ONE      = 8'h1F;
   localparam logic [7:0] MAGIC_TWO      = 8'h8B;
   localparam logic [7:0] METHOD_DEFLATE = 8'h08;

   localparam int FLAG_HCRC_BIT    = 1;
   localparam int FLAG_EXTRA_BIT   = 2;
   localparam int FLAG_NAME_BIT    = 3;
   localparam int FLAG_COMMENT_BIT = 4;

   localparam logic [15:0] FIXED_HEADER_LEN = 16'd10;
   localparam logic [15:0] FLAGS_POSITION   = 16'd4;

endpackage

// ===== hw/rtl/gzhs_parser.sv =====
// Header parse state and per-byte tagging for the gzip header skipper.
`include "gzip_header_skipper_defines.svh"

module gzhs_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  gzhs_pkg::req_type req,
   output gzhs_pkg::rsp_type rsp
);
   import gzhs_pkg::*;

   typedef enum logic [3:0] {
      PH_MAGIC1  = 4'd0,
      PH_MAGIC2  = 4'd1,
      PH_METHOD  = 4'd2,
      PH_FLAGS   = 4'd3,
      PH_FIXED   = 4'd4,
      PH_XLEN_LO = 4'd5,
      PH_XLEN_HI = 4'd6,
      PH_EXTRA   = 4'd7,
      PH_NAME    = 4'd8,
      PH_COMMENT = 4'd9,
      PH_CRC_LO  = 4'd10,
      PH_CRC_HI  = 4'd11,
      PH_PAYLOAD = 4'd12,
      PH_ERROR   = 4'd13
   } phase_type;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [7:0]  flags_ff, flags_in, flags_cur;
   logic [15:0] count_ff, count_in, count_cur;
   logic [7:0]  len_low_ff, len_low_in, len_low_cur;
   logic [1:0]  err_ff, err_in, err_cur;
   logic [1:0]  kind;
   logic [15:0] count_inc;
   logic [15:0] count_dec;
   logic [15:0] xlen;

   // first optional part at or after the given one, else payload
   function automatic phase_type next_part(phase_type from, logic [7:0] flags);
      phase_type nxt;
      nxt = PH_PAYLOAD;
      if (from <= PH_CRC_LO && flags[FLAG_HCRC_BIT])
         nxt = PH_CRC_LO;
      if (from <= PH_COMMENT && flags[FLAG_COMMENT_BIT])
         nxt = PH_COMMENT;
      if (from <= PH_NAME && flags[FLAG_NAME_BIT])
         nxt = PH_NAME;
      if (from <= PH_XLEN_LO && flags[FLAG_EXTRA_BIT])
         nxt = PH_XLEN_LO;
      return nxt;
   endfunction

   assign count_inc = count_cur + 16'd1;
   assign count_dec = count_cur - 16'd1;
   assign xlen      = {req.data_byte, len_low_cur};

   always_comb begin
      // start mark restarts from the reset state
      phase_cur   = req.start_of_stream ? PH_MAGIC1 : phase_ff;
      flags_cur   = req.start_of_stream ? 8'd0 : flags_ff;
      count_cur   = req.start_of_stream ? 16'd0 : count_ff;
      len_low_cur = req.start_of_stream ? 8'd0 : len_low_ff;
      err_cur     = req.start_of_stream ? KIND_HEADER : err_ff;

      phase_in   = phase_cur;
      flags_in   = flags_cur;
      count_in   = count_cur;
      len_low_in = len_low_cur;
      err_in     = err_cur;
      kind       = KIND_HEADER;

      case (phase_cur)
         PH_MAGIC1: begin
            if (req.data_byte != MAGIC_ONE) begin
               err_in   = KIND_BAD_MAGIC;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_MAGIC2;
            end
         end
         PH_MAGIC2: begin
            if (req.data_byte != MAGIC_TWO) begin
               err_in   = KIND_BAD_MAGIC;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_METHOD;
            end
         end
         PH_METHOD: begin
            if (req.data_byte != METHOD_DEFLATE) begin
               err_in   = KIND_BAD_METHOD;
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_FLAGS;
            end
         end
         PH_FLAGS: begin
            flags_in = req.data_byte;
            count_in = FLAGS_POSITION;
            phase_in = PH_FIXED;
         end
         PH_FIXED: begin
            count_in = count_inc;
            if (count_inc >= FIXED_HEADER_LEN) begin
               count_in = 16'd0;
               phase_in = next_part(PH_XLEN_LO, flags_cur);
            end
         end
         PH_XLEN_LO: begin
            len_low_in = req.data_byte;
            phase_in   = PH_XLEN_HI;
         end
         PH_XLEN_HI: begin
            count_in = xlen;
            phase_in = (xlen == 16'd0) ? next_part(PH_NAME, flags_cur) : PH_EXTRA;
         end
         PH_EXTRA: begin
            count_in = count_dec;
            if (count_dec == 16'd0)
               phase_in = next_part(PH_NAME, flags_cur);
         end
         PH_NAME: begin
            if (req.data_byte == 8'd0)
               phase_in = next_part(PH_COMMENT, flags_cur);
         end
         PH_COMMENT: begin
            if (req.data_byte == 8'd0)
               phase_in = next_part(PH_CRC_LO, flags_cur);
         end
         PH_CRC_LO: phase_in = PH_CRC_HI;
         PH_CRC_HI: phase_in = PH_PAYLOAD;
         PH_PAYLOAD: kind = KIND_PAYLOAD;
         default: phase_in = PH_ERROR;
      endcase

      if (phase_in == PH_ERROR)
         kind = err_in;

      rsp.byte_out     = req.data_byte;
      rsp.kind         = kind;
      rsp.header_flags = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC1;
         flags_ff   <= 8'd0;
         count_ff   <= 16'd0;
         len_low_ff <= 8'd0;
         err_ff     <= KIND_HEADER;
      end else if (step) begin
         phase_ff   <= phase_in;
         flags_ff   <= flags_in;
         count_ff   <= count_in;
         len_low_ff <= len_low_in;
         err_ff     <= err_in;
      end
   end

   `GZHS_ASSERT_NOW(a_error_has_kind, clock, reset, phase_ff == PH_ERROR, err_ff != KIND_HEADER, "error phase without an error kind")
   `GZHS_ASSERT_NEXT(a_error_sticky, clock, reset, step && !req.start_of_stream && phase_ff == PH_ERROR, phase_ff == PH_ERROR, "error left without a start mark")
   `GZHS_ASSERT_NEXT(a_payload_sticky, clock, reset, step && !req.start_of_stream && phase_ff == PH_PAYLOAD, phase_ff == PH_PAYLOAD, "payload left without a start mark")

endmodule

// ===== hw/rtl/gzip_header_skipper.sv =====
// Top level of the gzip header skipper: request register, parser and result register.
`include "gzip_header_skipper_defines.svh"

// gzip header skipper. Feed the bytes of a gzip stream as requests, one byte
// each, with start_of_stream set on the first byte of a new stream. Every
// request yields exactly one result carrying the same byte, a tag (header,
// payload, bad magic, unsupported method) and the latched flag byte. The
// block sustains one request per clock while results are not stalled: a request
// is taken into the input register, and the header parser updates its state
// and forms the result in the single cycle in which the request moves on into
// the result register, so rsp_valid rises once the request has passed from the
// input register into the result register. The input
// register keeps accepting while a finished result waits under rsp_stall, and
// only holds off (req_stall high) when both registers are full and the result
// is stalled. Errors are sticky until the next start mark; bytes after a
// complete header are tagged payload.
module gzip_header_skipper (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gzhs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gzhs_pkg::rsp_type rsp_payload
);
   import gzhs_pkg::*;

   logic    in_valid_ff;
   req_type in_req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type parsed;
   logic    advance;
   logic    req_take;

   // move the held request on unless the result register is full and stalled
   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   // hold off new requests only while the input register cannot drain
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // the parser's state advances exactly once per request, on its way out
   gzhs_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_req_ff),
      .rsp   (parsed)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_req_ff <= req_payload;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_ff <= parsed;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `GZHS_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff,
      "advanced request did not reach the result register")
   `GZHS_ASSERT_NEXT(a_blocked_request_held, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_req_ff), "blocked request was lost or changed")
   `GZHS_ASSERT_NOW(a_no_overwrite, clock, reset, req_take && in_valid_ff, advance,
      "request overwrote one still held")

endmodule
